// ----- src/olt_pkg.sv -----
// ----------------------------------------------------------------------------
// olt_pkg
// request and status codes and the scan summary shared by the lock table
// ----------------------------------------------------------------------------
package olt_pkg;

	localparam int KEY_W  = 64;
	localparam int ID_W   = 64;
	localparam int NOTE_W = 64;

	localparam logic [1:0] REQ_LOCK   = 2'd0;
	localparam logic [1:0] REQ_UNLOCK = 2'd1;
	localparam logic [1:0] REQ_CHECK  = 2'd2;
	localparam logic [1:0] REQ_QUERY  = 2'd3;

	localparam logic [2:0] ST_NONE        = 3'd0;
	localparam logic [2:0] ST_DOUBLE_LOCK = 3'd1;
	localparam logic [2:0] ST_NOT_OWNER   = 3'd2;
	localparam logic [2:0] ST_NOT_EXIST   = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

	// summary of one finished table scan, handed from the scanner to the top level
	typedef struct packed {
		logic              done;
		logic [1:0]        req_type;
		logic [KEY_W-1:0]  key;
		logic [ID_W-1:0]   owner;
		logic [NOTE_W-1:0] note;
		logic              hit;
		logic [ID_W-1:0]   hit_owner;
		logic [NOTE_W-1:0] hit_note;
		logic              free_found;
	} scan_sum_t;

endpackage

// ----- src/olt_store.sv -----
// ----------------------------------------------------------------------------
// olt_store
// entry memory (key, owner, note) and valid-bit memory, with registered read data
// ----------------------------------------------------------------------------
module olt_store #(
	parameter int TABLE_ENTRIES = 64,
	localparam int AW = $clog2(TABLE_ENTRIES)
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic                      rd_valid,
	output logic [olt_pkg::KEY_W-1:0] rd_key,
	output logic [olt_pkg::ID_W-1:0]  rd_owner,
	output logic [olt_pkg::NOTE_W-1:0] rd_note,
	input  logic                      e_we,
	input  logic [AW-1:0]             e_addr,
	input  logic [olt_pkg::KEY_W-1:0] e_key,
	input  logic [olt_pkg::ID_W-1:0]  e_owner,
	input  logic [olt_pkg::NOTE_W-1:0] e_note,
	input  logic                      v_we,
	input  logic [AW-1:0]             v_addr,
	input  logic                      v_data
);
	import olt_pkg::*;

	logic [KEY_W-1:0]  key_mem   [TABLE_ENTRIES];
	logic [ID_W-1:0]   owner_mem [TABLE_ENTRIES];
	logic [NOTE_W-1:0] note_mem  [TABLE_ENTRIES];
	logic              valid_mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (e_we) begin
			key_mem[e_addr]   <= e_key;
			owner_mem[e_addr] <= e_owner;
			note_mem[e_addr]  <= e_note;
		end
		if (rd_en) begin
			rd_key   <= key_mem[rd_addr];
			rd_owner <= owner_mem[rd_addr];
			rd_note  <= note_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			valid_mem[v_addr] <= v_data;
		end
		if (rd_en) begin
			rd_valid <= valid_mem[rd_addr];
		end
	end

endmodule

// ----- src/olt_scan.sv -----
// ----------------------------------------------------------------------------
// olt_scan
// sequencer: clearing pass after reset, then one full table scan per request
// ----------------------------------------------------------------------------
module olt_scan #(
	parameter int TABLE_ENTRIES = 64,
	localparam int AW = $clog2(TABLE_ENTRIES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [1:0]                 req_type,
	input  logic [olt_pkg::KEY_W-1:0]  lock_key,
	input  logic [olt_pkg::ID_W-1:0]   owner_id,
	input  logic [olt_pkg::NOTE_W-1:0] note_in,
	output logic                       busy,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  logic                       rd_valid,
	input  logic [olt_pkg::KEY_W-1:0]  rd_key,
	input  logic [olt_pkg::ID_W-1:0]   rd_owner,
	input  logic [olt_pkg::NOTE_W-1:0] rd_note,
	output logic                       clr_we,
	output logic [AW-1:0]              clr_addr,
	output olt_pkg::scan_sum_t         sum,
	output logic [AW-1:0]              hit_idx,
	output logic [AW-1:0]              free_idx
);
	import olt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CLEAR = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

	state_t            state_q;
	logic [AW-1:0]     addr_q;
	logic              issue_q;
	logic              pend_s1;
	logic              last_s1;
	logic [AW-1:0]     idx_s1;
	logic              hit_q;
	logic              free_q;
	logic [AW-1:0]     hit_idx_q;
	logic [AW-1:0]     free_idx_q;
	logic [ID_W-1:0]   hit_owner_q;
	logic [NOTE_W-1:0] hit_note_q;
	logic [1:0]        req_q;
	logic [KEY_W-1:0]  key_q;
	logic [ID_W-1:0]   owner_q;
	logic [NOTE_W-1:0] note_q;
	logic              accept;
	logic              match;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign rd_en    = (state_q == S_SCAN) && issue_q;
	assign rd_addr  = addr_q;
	assign clr_we   = (state_q == S_CLEAR);
	assign clr_addr = addr_q;
	assign match    = pend_s1 && rd_valid && (rd_key == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q  <= '0;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			last_s1 <= (addr_q == LAST);
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						addr_q  <= '0;
						issue_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						addr_q <= addr_q + 1'b1;
						if (addr_q == LAST) begin
							issue_q <= 1'b0;
						end
					end
					if (pend_s1 && last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (accept) begin
			req_q   <= req_type;
			key_q   <= lock_key;
			owner_q <= owner_id;
			note_q  <= note_in;
		end
	end

	// the first free entry seen is the lowest one, since the scan runs upward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (accept) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (pend_s1 && !rd_valid) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			hit_idx_q   <= idx_s1;
			hit_owner_q <= rd_owner;
			hit_note_q  <= rd_note;
		end
		if (pend_s1 && !rd_valid && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	always_comb begin
		sum.done       = (state_q == S_DONE);
		sum.req_type   = req_q;
		sum.key        = key_q;
		sum.owner      = owner_q;
		sum.note       = note_q;
		sum.hit        = hit_q;
		sum.hit_owner  = hit_owner_q;
		sum.hit_note   = hit_note_q;
		sum.free_found = free_q;
	end
	assign hit_idx  = hit_idx_q;
	assign free_idx = free_idx_q;

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> state_q == S_IDLE)
		else $error("scan did not return to idle after done");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> state_q == S_SCAN)
		else $error("read data returned outside a scan");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		match |-> !hit_q)
		else $error("key found in more than one valid entry");

endmodule

// ----- src/owned_lock_table.sv -----
// ----------------------------------------------------------------------------
// owned_lock_table
// lock table with owner ids: lock, unlock, check owner and query by key
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   start high, busy low      req_type, lock_key, owner_id, note_in
//  result    done high for one cycle   ok, status, holder_id, note_out
//
//  each transaction scans all TABLE_ENTRIES entries through the one read port,
//  one entry a cycle; busy falls as the result strobe rises, so a new request
//  can be taken while the strobe is shown
//  after reset a clearing pass over all TABLE_ENTRIES entries resets the valid bits,
//  with busy high
//  the receiver cannot stall: a result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module owned_lock_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 req_type,
	input  logic [olt_pkg::KEY_W-1:0]  lock_key,
	input  logic [olt_pkg::ID_W-1:0]   owner_id,
	input  logic [olt_pkg::NOTE_W-1:0] note_in,
	output logic                       done,
	output logic                       ok,
	output logic [2:0]                 status,
	output logic [olt_pkg::ID_W-1:0]   holder_id,
	output logic [olt_pkg::NOTE_W-1:0] note_out
);
	import olt_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);

	scan_sum_t         sum;
	logic [AW-1:0]     hit_idx;
	logic [AW-1:0]     free_idx;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              rd_valid;
	logic [KEY_W-1:0]  rd_key;
	logic [ID_W-1:0]   rd_owner;
	logic [NOTE_W-1:0] rd_note;
	logic              clr_we;
	logic [AW-1:0]     clr_addr;

	logic              dec_ok;
	logic [2:0]        dec_status;
	logic [ID_W-1:0]   dec_holder;
	logic [NOTE_W-1:0] dec_note;
	logic              dec_e_we;
	logic              dec_v_we;
	logic              dec_v_data;
	logic [AW-1:0]     dec_v_addr;
	logic              v_we;
	logic [AW-1:0]     v_addr;
	logic              v_data;

	logic              done_q;
	logic              ok_q;
	logic [2:0]        status_q;
	logic [ID_W-1:0]   holder_q;
	logic [NOTE_W-1:0] note_q;

	olt_scan #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.lock_key (lock_key),
		.owner_id (owner_id),
		.note_in  (note_in),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_valid (rd_valid),
		.rd_key   (rd_key),
		.rd_owner (rd_owner),
		.rd_note  (rd_note),
		.clr_we   (clr_we),
		.clr_addr (clr_addr),
		.sum      (sum),
		.hit_idx  (hit_idx),
		.free_idx (free_idx)
	);

	olt_store #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_store (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_valid (rd_valid),
		.rd_key   (rd_key),
		.rd_owner (rd_owner),
		.rd_note  (rd_note),
		.e_we     (dec_e_we),
		.e_addr   (free_idx),
		.e_key    (sum.key),
		.e_owner  (sum.owner),
		.e_note   (sum.note),
		.v_we     (v_we),
		.v_addr   (v_addr),
		.v_data   (v_data)
	);

	// decide the result and the write-back once the scan is complete
	always_comb begin
		dec_ok     = 1'b0;
		dec_status = ST_NONE;
		dec_holder = '0;
		dec_note   = '0;
		dec_e_we   = 1'b0;
		dec_v_we   = 1'b0;
		dec_v_data = 1'b0;
		dec_v_addr = hit_idx;
		if (sum.req_type == REQ_LOCK) begin
			if (sum.hit) begin
				dec_status = (sum.hit_owner == sum.owner) ? ST_DOUBLE_LOCK : ST_NOT_OWNER;
			end else if (!sum.free_found) begin
				dec_status = ST_TABLE_FULL;
			end else begin
				dec_ok     = 1'b1;
				dec_e_we   = sum.done;
				dec_v_we   = sum.done;
				dec_v_data = 1'b1;
				dec_v_addr = free_idx;
			end
		end else if (!sum.hit) begin
			dec_status = ST_NOT_EXIST;
		end else if (sum.req_type == REQ_QUERY) begin
			dec_ok     = 1'b1;
			dec_holder = sum.hit_owner;
			dec_note   = sum.hit_note;
		end else if (sum.hit_owner != sum.owner) begin
			dec_status = ST_NOT_OWNER;
		end else begin
			dec_ok   = 1'b1;
			dec_note = sum.hit_note;
			dec_v_we = sum.done && (sum.req_type == REQ_UNLOCK);
		end
	end

	// clearing pass owns the valid port until the table first goes idle
	assign v_we   = clr_we || dec_v_we;
	assign v_addr = clr_we ? clr_addr : dec_v_addr;
	assign v_data = clr_we ? 1'b0 : dec_v_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sum.done;
		end
	end

	always_ff @(posedge clk) begin
		if (sum.done) begin
			ok_q     <= dec_ok;
			status_q <= dec_status;
			holder_q <= dec_holder;
			note_q   <= dec_note;
		end
	end

	assign done      = done_q;
	assign ok        = ok_q;
	assign status    = status_q;
	assign holder_id = holder_q;
	assign note_out  = note_q;

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && ok_q |-> status_q == ST_NONE)
		else $error("successful transaction with a failure status");

	a_fail_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !ok_q |-> status_q != ST_NONE && status_q <= ST_TABLE_FULL)
		else $error("failed transaction without a valid failure status");

	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !$past(done_q))
		else $error("result strobe held for more than one cycle");

endmodule

// ----- sim/owned_lock_table_test.sv -----
// ----------------------------------------------------------------------------
// owned_lock_table_test
// self-checking bench for the owned lock table: a short table of directed
// requests, then random request streams that fill, drain and mix the table,
// with each result checked against its planned value or a behavioral copy of the table
// ----------------------------------------------------------------------------
module owned_lock_table_test;

	import olt_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int LATENCY       = TABLE_ENTRIES + 3;
	localparam int NUM_DIRECTED  = 20;
	localparam int NUM_RANDOM    = 1130;
	localparam int ROUND_LEN     = 96;
	localparam int NUM_KEY_POOL  = 8;
	localparam int NUM_ID_POOL   = 6;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// traffic shapes for the random part
	localparam logic [1:0] MIX_ANY   = 2'd0;
	localparam logic [1:0] MIX_FILL  = 2'd1;
	localparam logic [1:0] MIX_DRAIN = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [KEY_W-1:0]  key;
		logic [ID_W-1:0]   owner;
		logic [NOTE_W-1:0] note;
	} lock_req_t;

	typedef struct packed {
		logic              ok;
		logic [2:0]        status;
		logic [ID_W-1:0]   holder;
		logic [NOTE_W-1:0] note;
	} lock_resp_t;

	typedef struct packed {
		lock_req_t  req;
		logic       typed;
		lock_resp_t resp;
	} plan_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic [1:0]        req_type  = REQ_LOCK;
	logic [KEY_W-1:0]  lock_key  = '0;
	logic [ID_W-1:0]   owner_id  = '0;
	logic [NOTE_W-1:0] note_in   = '0;
	logic              busy;
	logic              done;
	logic              ok;
	logic [2:0]        status;
	logic [ID_W-1:0]   holder_id;
	logic [NOTE_W-1:0] note_out;

	// behavioral copy of the table
	logic              held_valid [TABLE_ENTRIES];
	logic [KEY_W-1:0]  held_key   [TABLE_ENTRIES];
	logic [ID_W-1:0]   held_owner [TABLE_ENTRIES];
	logic [NOTE_W-1:0] held_note  [TABLE_ENTRIES];

	lock_resp_t        pending_resp [$];
	plan_row_t         plan [NUM_DIRECTED];
	logic [KEY_W-1:0]  key_pool [NUM_KEY_POOL];
	logic [ID_W-1:0]   id_pool  [NUM_ID_POOL];

	int n_errors   = 0;
	int n_accepted = 0;
	int n_results  = 0;
	int n_ok       = 0;
	int n_status [5];

	owned_lock_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.lock_key (lock_key),
		.owner_id (owner_id),
		.note_in  (note_in),
		.done     (done),
		.ok       (ok),
		.status   (status),
		.holder_id(holder_id),
		.note_out (note_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// applies one request to the table copy and returns its result
	function automatic lock_resp_t lock_table_apply(lock_req_t r);
		lock_resp_t res;
		int hit;
		int slot;
		res  = '0;
		hit  = -1;
		slot = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit < 0 && held_valid[i] && held_key[i] == r.key)
				hit = i;
			if (slot < 0 && !held_valid[i])
				slot = i;
		end
		if (r.kind == REQ_LOCK) begin
			if (hit >= 0) begin
				res.status = (held_owner[hit] == r.owner) ? ST_DOUBLE_LOCK : ST_NOT_OWNER;
			end else if (slot < 0) begin
				res.status = ST_TABLE_FULL;
			end else begin
				held_valid[slot] = 1'b1;
				held_key[slot]   = r.key;
				held_owner[slot] = r.owner;
				held_note[slot]  = r.note;
				res.ok           = 1'b1;
			end
		end else if (hit < 0) begin
			res.status = ST_NOT_EXIST;
		end else if (r.kind == REQ_QUERY) begin
			res.ok     = 1'b1;
			res.holder = held_owner[hit];
			res.note   = held_note[hit];
		end else if (held_owner[hit] != r.owner) begin
			res.status = ST_NOT_OWNER;
		end else begin
			res.ok   = 1'b1;
			res.note = held_note[hit];
			if (r.kind == REQ_UNLOCK)
				held_valid[hit] = 1'b0;
		end
		return res;
	endfunction

	// index of a random held entry, or -1 with the table empty
	function automatic int pick_held();
		int n_held;
		int nth;
		n_held = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (held_valid[i])
				n_held++;
		if (n_held == 0)
			return -1;
		nth = $urandom_range(0, n_held - 1);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (held_valid[i]) begin
				if (nth == 0)
					return i;
				nth--;
			end
		end
		return -1;
	endfunction

	function automatic lock_req_t random_req(logic [1:0] mix);
		lock_req_t r;
		int roll;
		int idx;
		int held_pct;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				r.kind = (roll < 85) ? REQ_LOCK : 2'($urandom_range(1, 3));
			end
			MIX_DRAIN: begin
				if (roll < 60)
					r.kind = REQ_UNLOCK;
				else if (roll < 80)
					r.kind = REQ_CHECK;
				else if (roll < 90)
					r.kind = REQ_QUERY;
				else
					r.kind = REQ_LOCK;
			end
			default: begin
				r.kind = 2'($urandom_range(0, 3));
			end
		endcase
		idx      = pick_held();
		held_pct = (r.kind == REQ_LOCK) ? 15 : 75;
		roll     = $urandom_range(0, 99);
		if (idx >= 0 && roll < held_pct) begin
			r.key   = held_key[idx];
			r.owner = ($urandom_range(0, 99) < 75) ? held_owner[idx]
				: id_pool[$urandom_range(0, NUM_ID_POOL - 1)];
		end else begin
			r.key   = (roll < held_pct + 15) ? key_pool[$urandom_range(0, NUM_KEY_POOL - 1)]
				: rand64();
			r.owner = ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, NUM_ID_POOL - 1)]
				: rand64();
		end
		roll = $urandom_range(0, 19);
		r.note = (roll == 0) ? '0 : (roll == 1) ? ONES : rand64();
		return r;
	endfunction

	function automatic plan_row_t mk_row(logic [1:0] kind, logic [63:0] key,
		logic [63:0] owner, logic [63:0] note, logic typed, logic exp_ok,
		logic [2:0] exp_status, logic [63:0] exp_holder, logic [63:0] exp_note);
		plan_row_t row;
		row.req   = '{kind: kind, key: key, owner: owner, note: note};
		row.typed = typed;
		row.resp  = '{ok: exp_ok, status: exp_status, holder: exp_holder, note: exp_note};
		return row;
	endfunction

	// holds the transaction until it is taken, then records what it must return
	task automatic issue(lock_req_t r, logic typed, lock_resp_t typed_resp);
		lock_resp_t predicted;
		start    <= 1'b1;
		req_type <= r.kind;
		lock_key <= r.key;
		owner_id <= r.owner;
		note_in  <= r.note;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted = lock_table_apply(r);
		pending_resp.push_back(typed ? typed_resp : predicted);
		n_accepted++;
	endtask

	task automatic maybe_idle(int item);
		// idle gaps at random, but none in the middle of the random part
		if ((item < 400 || item > 700) && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, LATENCY + 8))
				@(posedge clk);
		end
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin
		lock_resp_t want;
		if (arst_n && done === 1'b1) begin
			n_results++;
			if (ok === 1'b1)
				n_ok++;
			if (status <= ST_TABLE_FULL)
				n_status[status]++;
			if (pending_resp.size() == 0) begin
				$display("%0t: unexpected result, ok %b status %0d holder %h note %h",
					$time, ok, status, holder_id, note_out);
				n_errors++;
			end else begin
				want = pending_resp.pop_front();
				check_field("ok", 64'(want.ok), 64'(ok));
				check_field("status", 64'(want.status), 64'(status));
				check_field("holder_id", want.holder, holder_id);
				check_field("note_out", want.note, note_out);
			end
		end
	end

	initial begin
		int guard;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			held_valid[i] = 1'b0;
			held_key[i]   = '0;
			held_owner[i] = '0;
			held_note[i]  = '0;
		end
		for (int i = 0; i < 5; i++)
			n_status[i] = 0;
		key_pool[0] = '0;
		key_pool[1] = ONES;
		for (int i = 2; i < NUM_KEY_POOL; i++)
			key_pool[i] = rand64();
		id_pool[0] = '0;
		id_pool[1] = ONES;
		for (int i = 2; i < NUM_ID_POOL; i++)
			id_pool[i] = rand64();

		plan[0]  = mk_row(REQ_QUERY,  '0,   '0,   '0,   1'b1, 1'b0, ST_NOT_EXIST,   '0,   '0);
		plan[1]  = mk_row(REQ_UNLOCK, ONES, ONES, ONES, 1'b1, 1'b0, ST_NOT_EXIST,   '0,   '0);
		plan[2]  = mk_row(REQ_CHECK,  '0,   '0,   '0,   1'b1, 1'b0, ST_NOT_EXIST,   '0,   '0);
		plan[3]  = mk_row(REQ_LOCK,   '0,   '0,   ONES, 1'b1, 1'b1, ST_NONE,        '0,   '0);
		plan[4]  = mk_row(REQ_LOCK,   '0,   '0,   '0,   1'b1, 1'b0, ST_DOUBLE_LOCK, '0,   '0);
		plan[5]  = mk_row(REQ_LOCK,   '0,   ONES, '0,   1'b1, 1'b0, ST_NOT_OWNER,   '0,   '0);
		plan[6]  = mk_row(REQ_QUERY,  '0,   ONES, '0,   1'b1, 1'b1, ST_NONE,        '0,   ONES);
		plan[7]  = mk_row(REQ_CHECK,  '0,   ONES, '0,   1'b1, 1'b0, ST_NOT_OWNER,   '0,   '0);
		plan[8]  = mk_row(REQ_CHECK,  '0,   '0,   '0,   1'b1, 1'b1, ST_NONE,        '0,   ONES);
		plan[9]  = mk_row(REQ_UNLOCK, '0,   ONES, '0,   1'b1, 1'b0, ST_NOT_OWNER,   '0,   '0);
		plan[10] = mk_row(REQ_LOCK,   ONES, ONES, '0,   1'b1, 1'b1, ST_NONE,        '0,   '0);
		plan[11] = mk_row(REQ_QUERY,  ONES, '0,   ONES, 1'b1, 1'b1, ST_NONE,        ONES, '0);
		plan[12] = mk_row(REQ_UNLOCK, ONES, '0,   '0,   1'b1, 1'b0, ST_NOT_OWNER,   '0,   '0);
		plan[13] = mk_row(REQ_UNLOCK, ONES, ONES, '0,   1'b1, 1'b1, ST_NONE,        '0,   '0);
		plan[14] = mk_row(REQ_QUERY,  ONES, '0,   '0,   1'b1, 1'b0, ST_NOT_EXIST,   '0,   '0);
		plan[15] = mk_row(REQ_LOCK, 64'h0123_4567_89AB_CDEF, 64'hA5A5_A5A5_A5A5_A5A5,
			64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0, ST_NONE, '0, '0);
		plan[16] = mk_row(REQ_QUERY, 64'h0123_4567_89AB_CDEF, '0, '0, 1'b0, 1'b0, ST_NONE,
			'0, '0);
		plan[17] = mk_row(REQ_CHECK, 64'h0123_4567_89AB_CDEF, 64'hA5A5_A5A5_A5A5_A5A5,
			'0, 1'b0, 1'b0, ST_NONE, '0, '0);
		plan[18] = mk_row(REQ_UNLOCK, '0,   '0,   '0,   1'b1, 1'b1, ST_NONE,        '0,   ONES);
		plan[19] = mk_row(REQ_QUERY,  '0,   '0,   '0,   1'b1, 1'b0, ST_NOT_EXIST,   '0,   '0);

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			issue(plan[i].req, plan[i].typed, plan[i].resp);
			maybe_idle(0);
		end
		// rounds cycle through mixed, fill, mixed and drain traffic
		for (int i = 0; i < NUM_RANDOM; i++) begin
			issue(random_req(2'((i / ROUND_LEN) % 4)), 1'b0, '0);
			maybe_idle(i);
		end
		start <= 1'b0;

		guard = 0;
		while (pending_resp.size() != 0 && guard < 20 * LATENCY) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 10)
			@(posedge clk);
		if (pending_resp.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_resp.size());
			n_errors++;
		end

		$display("covered %0d requests, %0d results, %0d succeeded", n_accepted, n_results,
			n_ok);
		$display("failures by kind: double lock %0d, not owner %0d, not exist %0d, full %0d",
			n_status[ST_DOUBLE_LOCK], n_status[ST_NOT_OWNER], n_status[ST_NOT_EXIST],
			n_status[ST_TABLE_FULL]);
		if (n_errors == 0) begin
			$display("owned_lock_table_test: PASS");
		end else begin
			$display("owned_lock_table_test: FAIL");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("%0t: run timed out", $time);
		$display("owned_lock_table_test: FAIL");
		$finish;
	end

endmodule
